[rtl/core/assert_macros.svh]
// Assertion macros used by the poll rate controller top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(lbl, cond, cons, msg) \
  `ASSERT_RST(lbl, (cond) |-> (cons), msg)

`endif

[rtl/core/prc_pkg.sv]
// Types, codes and constants of the poll rate controller.
`timescale 1ns / 1ps
package prc_pkg;

  // Field widths
  localparam int unsigned OpW       = 4;
  localparam int unsigned QsW       = 23;
  localparam int unsigned ShortW    = 16;
  localparam int unsigned RateW     = 31;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned InTdataW  = 32;
  localparam int unsigned OutTdataW = 40;

  // Milliseconds per quarter-second tick
  localparam logic [9:0] MsPerQuarter = 10'd250;

  // Interval values loaded at reset
  localparam logic [QsW-1:0]    LongPollRst  = 23'd20;
  localparam logic [ShortW-1:0] ShortPollRst = 16'd2;

  typedef enum logic [OpW-1:0] {
    OP_TICK        = 4'd0,
    OP_START       = 4'd1,
    OP_STOP        = 4'd2,
    OP_CHECKIN_RSP = 4'd3,
    OP_FAST_STOP   = 4'd4,
    OP_SET_LONG    = 4'd5,
    OP_SET_SHORT   = 4'd6,
    OP_RESTORE     = 4'd7,
    OP_OTHER       = 4'd8
  } prc_op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DENIED  = 2'd1,
    ST_INVALID = 2'd2,
    ST_UNSUP   = 2'd3
  } prc_status_e;

  typedef enum logic [CfgAddrW-1:0] {
    REG_CHECKIN_INT = 3'd0,
    REG_WIN_DEFAULT = 3'd1,
    REG_WIN_MAX     = 3'd2,
    REG_LONG_MIN    = 3'd3,
    REG_LONG_INIT   = 3'd4,
    REG_SHORT_INIT  = 3'd5
  } prc_reg_e;

  typedef struct packed {
    logic              fast;
    logic              win_act;
    logic [ShortW-1:0] win_left;
    logic              ci_act;
    logic [QsW-1:0]    ci_left;
    logic [QsW-1:0]    long_iv;
    logic [ShortW-1:0] short_iv;
  } prc_state_t;

  typedef struct packed {
    logic [QsW-1:0]    ci_int;
    logic [ShortW-1:0] win_def;
    logic [ShortW-1:0] win_max;
    logic [QsW-1:0]    long_min;
  } prc_cfg_t;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic           addressed_ok;
    logic           start_fast;
    logic [QsW-1:0] cmd_value;
    logic           ota_busy;
  } prc_req_t;

  typedef struct packed {
    prc_status_e      status;
    logic             rate_update;
    logic [RateW-1:0] poll_rate_ms;
    logic             send_checkin;
    logic             fast_polling;
  } prc_rsp_t;

endpackage

[rtl/core/prc_rate.sv]
// Interval to milliseconds conversion with saturation.
`timescale 1ns / 1ps
module prc_rate (
  input  logic [prc_pkg::QsW-1:0]   interval_i,
  output logic [prc_pkg::RateW-1:0] rate_ms_o
);
  import prc_pkg::*;

  logic [QsW+9:0] prod;

  // Scale quarter-seconds to ms
  assign prod = {10'd0, interval_i} * {{QsW{1'b0}}, MsPerQuarter};

  // Clamp to the largest 31-bit rate
  assign rate_ms_o = (|prod[QsW+9:RateW]) ? {RateW{1'b1}} : prod[RateW-1:0];

endmodule

[rtl/core/prc_step.sv]
// Next-state and result logic for one poll-control request.
`timescale 1ns / 1ps
module prc_step (
  input  prc_pkg::prc_state_t st_i,
  input  prc_pkg::prc_cfg_t   cfg_i,
  input  prc_pkg::prc_req_t   req_i,
  output prc_pkg::prc_state_t st_o,
  output prc_pkg::prc_rsp_t   rsp_o
);
  import prc_pkg::*;

  logic [QsW-1:0]    win_req;
  logic [QsW-1:0]    win_clamp;
  logic [ShortW-1:0] win_len;
  logic [QsW-1:0]    rate_iv;
  logic [RateW-1:0]  rate_ms;
  logic              upd;
  logic              checkin;
  prc_status_e       status;

  // Resolve the requested fast-poll window length
  always_comb begin
    win_req   = (req_i.cmd_value == '0) ? {7'd0, cfg_i.win_def} : req_i.cmd_value;
    win_clamp = ((cfg_i.win_max != '0) && (win_req > {7'd0, cfg_i.win_max}))
                ? {7'd0, cfg_i.win_max} : win_req;
    win_len   = (|win_clamp[QsW-1:ShortW]) ? {ShortW{1'b1}} : win_clamp[ShortW-1:0];
  end

  // Apply the request to the state
  always_comb begin
    st_o    = st_i;
    status  = ST_OK;
    upd     = 1'b0;
    rate_iv = '0;
    checkin = 1'b0;
    unique case (req_i.op)
      OP_TICK: begin
        // Count down the fast window, drop back to the long rate at its end
        if (st_i.win_act) begin
          if (st_i.win_left <= 16'd1) begin
            st_o.win_act  = 1'b0;
            st_o.win_left = '0;
            st_o.fast     = 1'b0;
            upd           = !req_i.ota_busy;
            rate_iv       = st_i.long_iv;
          end else begin
            st_o.win_left = st_i.win_left - 16'd1;
          end
        end
        // Count down the check-in period, reload or stop at its end
        if (st_i.ci_act) begin
          if (st_i.ci_left <= 23'd1) begin
            if (cfg_i.ci_int == '0) begin
              st_o.ci_act  = 1'b0;
              st_o.ci_left = '0;
            end else begin
              checkin      = 1'b1;
              st_o.ci_left = cfg_i.ci_int;
            end
          end else begin
            st_o.ci_left = st_i.ci_left - 23'd1;
          end
        end
      end
      OP_START: begin
        if (cfg_i.ci_int != '0) begin
          st_o.ci_act  = 1'b1;
          st_o.ci_left = cfg_i.ci_int;
        end
      end
      OP_STOP: begin
        st_o.ci_act   = 1'b0;
        st_o.ci_left  = '0;
        st_o.win_act  = 1'b0;
        st_o.win_left = '0;
        st_o.fast     = 1'b0;
        upd           = !req_i.ota_busy;
        rate_iv       = st_i.long_iv;
      end
      OP_RESTORE: begin
        upd     = !req_i.ota_busy;
        rate_iv = st_i.fast ? {7'd0, st_i.short_iv} : st_i.long_iv;
      end
      default: begin
        // Commands act only when addressed to this endpoint
        if (req_i.addressed_ok) begin
          unique case (req_i.op)
            OP_CHECKIN_RSP: begin
              if (req_i.start_fast && (win_len != '0)) begin
                st_o.fast     = 1'b1;
                st_o.win_act  = 1'b1;
                st_o.win_left = win_len;
                upd           = !req_i.ota_busy;
                rate_iv       = {7'd0, st_i.short_iv};
              end
            end
            OP_FAST_STOP: begin
              if (!st_i.fast) begin
                status = ST_DENIED;
              end else begin
                st_o.win_act  = 1'b0;
                st_o.win_left = '0;
                st_o.fast     = 1'b0;
                upd           = !req_i.ota_busy;
                rate_iv       = st_i.long_iv;
              end
            end
            OP_SET_LONG: begin
              if (req_i.cmd_value < cfg_i.long_min) begin
                status = ST_INVALID;
              end else begin
                st_o.long_iv = req_i.cmd_value;
                upd          = !st_i.fast && !req_i.ota_busy;
                rate_iv      = req_i.cmd_value;
              end
            end
            OP_SET_SHORT: begin
              st_o.short_iv = req_i.cmd_value[ShortW-1:0];
              upd           = st_i.fast && !req_i.ota_busy;
              rate_iv       = {7'd0, req_i.cmd_value[ShortW-1:0]};
            end
            default: begin
              status = ST_UNSUP;
            end
          endcase
        end
      end
    endcase
  end

  prc_rate u_rate (
    .interval_i (rate_iv),
    .rate_ms_o  (rate_ms)
  );

  // Assemble the result
  always_comb begin
    rsp_o.status       = status;
    rsp_o.rate_update  = upd;
    rsp_o.poll_rate_ms = upd ? rate_ms : '0;
    rsp_o.send_checkin = checkin;
    rsp_o.fast_polling = st_o.fast;
  end

endmodule

[rtl/core/poll_rate_controller_unit.sv]
// Top level of the poll rate controller: request stage, state and result stage.
//
//  channel   | direction | payload
//  ----------+-----------+------------------------------------------------------
//  s_axis    | in        | tuser: op; tdata: addressed_ok, start_fast, cmd_value,
//            |           |        ota_busy
//  m_axis    | out       | tdata: status, rate_update, poll_rate_ms,
//            |           |        send_checkin, fast_polling
//  cfg       | in        | cfg_addr_i register index, cfg_data_i value
//
// One request per cycle sustained while m_axis is not stalled; each result is held
// in the result register that drives m_axis. The interval multiply and saturate sit
// in the single step between the request and result registers.
// Reset clears all state at once, loads the long interval with 20 and the short
// interval with 2; no clearing pass. A stalled m_axis holds the result and
// backs up s_axis through the request stage. cfg is always ready.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module poll_rate_controller_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [0] addressed_ok, [1] start_fast, [24:2] cmd_value, [25] ota_busy, [31:26] zero
  input  logic [prc_pkg::InTdataW-1:0]     s_axis_tdata,
  // [3:0] op
  input  logic [prc_pkg::OpW-1:0]          s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [1:0] status, [2] rate_update, [33:3] poll_rate_ms, [34] send_checkin,
  // [35] fast_polling, [39:36] zero
  output logic [prc_pkg::OutTdataW-1:0]    m_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [prc_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  logic [prc_pkg::QsW-1:0]          cfg_data_i
);
  import prc_pkg::*;

  logic       in_valid_q, in_valid_d;
  prc_req_t   in_req_q;
  logic       out_valid_q, out_valid_d;
  prc_rsp_t   out_rsp_q;
  prc_state_t st_q, st_d;
  prc_cfg_t   cfg_q;
  prc_rsp_t   rsp;
  logic       s_acc;
  logic       advance;

  // Handshakes
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_valid_d    = s_acc || (in_valid_q && !advance);
  assign out_valid_d   = advance || (out_valid_q && !m_axis_tready);
  assign cfg_ready_o   = 1'b1;

  // Configuration registers; writes to the initial interval registers are not stored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        REG_CHECKIN_INT: cfg_q.ci_int   <= cfg_data_i;
        REG_WIN_DEFAULT: cfg_q.win_def  <= cfg_data_i[ShortW-1:0];
        REG_WIN_MAX:     cfg_q.win_max  <= cfg_data_i[ShortW-1:0];
        REG_LONG_MIN:    cfg_q.long_min <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '{fast: 1'b0, win_act: 1'b0, win_left: '0, ci_act: 1'b0,
                       ci_left: '0, long_iv: LongPollRst, short_iv: ShortPollRst};
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        st_q <= st_d;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_req_q.op           <= s_axis_tuser;
      in_req_q.addressed_ok <= s_axis_tdata[0];
      in_req_q.start_fast   <= s_axis_tdata[1];
      in_req_q.cmd_value    <= s_axis_tdata[24:2];
      in_req_q.ota_busy     <= s_axis_tdata[25];
    end
    if (advance) begin
      out_rsp_q <= rsp;
    end
  end

  prc_step u_step (
    .st_i  (st_q),
    .cfg_i (cfg_q),
    .req_i (in_req_q),
    .st_o  (st_d),
    .rsp_o (rsp)
  );

  // Drive the result channel
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_rsp_q.fast_polling, out_rsp_q.send_checkin,
                          out_rsp_q.poll_rate_ms, out_rsp_q.rate_update,
                          out_rsp_q.status};

  // Consistency of the kept state and the result
  `ASSERT_RST(a_win_fast, st_q.win_act == st_q.fast, "fast flag and window disagree")
  `ASSERT_RST(a_win_cnt, st_q.win_act == (st_q.win_left != '0), "window count mismatch")
  `ASSERT_RST(a_ci_cnt, st_q.ci_act == (st_q.ci_left != '0), "check-in count mismatch")
  `ASSERT_IMPLIES(a_rate_zero, out_valid_q && !out_rsp_q.rate_update,
                  out_rsp_q.poll_rate_ms == '0, "rate without update")

endmodule

[test/poll_rate_controller_unit_tb.sv]
// Self-checking testbench of the poll rate controller: scripted requests, then random phases.
`timescale 1ns / 1ps
module poll_rate_controller_unit_tb;
  import prc_pkg::*;

  // Highest op code the tuser field can carry; codes above OP_OTHER act as other command
  localparam logic [OpW-1:0] OP_LAST_CODE = 4'd15;
  localparam logic [QsW-1:0] QS_TOP       = 23'd7208960;
  localparam logic [63:0]    RATE_SAT     = 64'h7FFF_FFFF;
  localparam int unsigned    PHASES       = 10;
  localparam int unsigned    PHASE_ITEMS  = 165;
  localparam int unsigned    IDLE_LIMIT   = 1000;
  localparam int unsigned    MAX_REPORTS  = 40;

  typedef struct {
    logic [OpW-1:0] op;
    logic           addressed;
    logic           start_fast;
    logic [QsW-1:0] value;
    logic           ota;
  } poll_request_t;

  typedef struct {
    prc_status_e      status;
    logic             rate_update;
    logic [RateW-1:0] rate_ms;
    logic             send_checkin;
    logic             fast_polling;
  } poll_result_t;

  typedef struct {
    logic          is_write;
    prc_reg_e      reg_idx;
    poll_request_t req;
    logic          typed;
    poll_result_t  res;
  } script_row_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata  = '0;
  logic [OpW-1:0]       s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgAddrW-1:0]  cfg_addr_i    = '0;
  logic [QsW-1:0]       cfg_data_i    = '0;

  // Predicted controller state
  logic              fast_q     = 1'b0;
  logic              win_act_q  = 1'b0;
  logic [ShortW-1:0] win_left_q = '0;
  logic              ci_act_q   = 1'b0;
  logic [QsW-1:0]    ci_left_q  = '0;
  logic [QsW-1:0]    long_iv_q  = LongPollRst;
  logic [ShortW-1:0] short_iv_q = ShortPollRst;

  // Predicted register contents
  logic [QsW-1:0]    ci_int_r     = '0;
  logic [ShortW-1:0] win_def_r    = '0;
  logic [ShortW-1:0] win_max_r    = '0;
  logic [QsW-1:0]    long_min_r   = '0;
  logic [QsW-1:0]    long_init_r  = LongPollRst;
  logic [ShortW-1:0] short_init_r = ShortPollRst;

  poll_result_t expected_results[$];
  script_row_t  script[$];

  int err_count         = 0;
  int requests_sent     = 0;
  int results_seen      = 0;
  int checkins_seen     = 0;
  int rate_updates_seen = 0;
  int refusals_seen     = 0;
  int settings_applied  = 0;
  int stall_cycles      = 0;
  int rx_wait           = 0;
  bit tx_quiet          = 1'b0;
  bit rx_quiet          = 1'b0;

  poll_rate_controller_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Draw the idle cycles ahead of one handshake
  function automatic int draw_gap(input bit quiet);
    if (quiet) return 0;
    return $urandom_range(0, 13);
  endfunction

  // Set the fast flag and issue the matching rate unless a download owns it
  function automatic void issue_rate(input logic fast_sel, input logic ota,
                                     inout poll_result_t r);
    logic [63:0] ms;
    fast_q = fast_sel;
    if (!ota) begin
      ms = (fast_sel ? 64'(short_iv_q) : 64'(long_iv_q)) * 64'(MsPerQuarter);
      if (ms > RATE_SAT) ms = RATE_SAT;
      r.rate_update = 1'b1;
      r.rate_ms     = ms[RateW-1:0];
    end
  endfunction

  function automatic void close_window(input logic ota, inout poll_result_t r);
    win_act_q  = 1'b0;
    win_left_q = '0;
    issue_rate(1'b0, ota, r);
  endfunction

  // Advance the predicted state by one request and return its result
  function automatic poll_result_t advance_poll_state(input poll_request_t q);
    poll_result_t   r;
    logic [QsW-1:0] qs;
    r = '{status: ST_OK, rate_update: 1'b0, rate_ms: '0, send_checkin: 1'b0,
          fast_polling: 1'b0};
    if (q.op == OP_TICK) begin
      if (win_act_q) begin
        if (win_left_q <= 16'd1) close_window(q.ota, r);
        else win_left_q = win_left_q - 16'd1;
      end
      if (ci_act_q) begin
        if (ci_left_q <= 23'd1) begin
          if (ci_int_r == '0) begin
            ci_act_q  = 1'b0;
            ci_left_q = '0;
          end else begin
            r.send_checkin = 1'b1;
            ci_left_q      = ci_int_r;
          end
        end else begin
          ci_left_q = ci_left_q - 23'd1;
        end
      end
    end else if (q.op == OP_START) begin
      if (ci_int_r != '0) begin
        ci_act_q  = 1'b1;
        ci_left_q = ci_int_r;
      end
    end else if (q.op == OP_STOP) begin
      ci_act_q  = 1'b0;
      ci_left_q = '0;
      close_window(q.ota, r);
    end else if (q.op == OP_RESTORE) begin
      issue_rate(fast_q, q.ota, r);
    end else if (q.addressed) begin
      case (q.op)
        OP_CHECKIN_RSP: begin
          if (q.start_fast) begin
            qs = q.value;
            if (qs == '0) qs = QsW'(win_def_r);
            if (win_max_r != '0 && qs > QsW'(win_max_r)) qs = QsW'(win_max_r);
            if (qs > 23'h00FFFF) qs = 23'h00FFFF;
            if (qs != '0) begin
              issue_rate(1'b1, q.ota, r);
              win_act_q  = 1'b1;
              win_left_q = qs[ShortW-1:0];
            end
          end
        end
        OP_FAST_STOP: begin
          if (!fast_q) r.status = ST_DENIED;
          else close_window(q.ota, r);
        end
        OP_SET_LONG: begin
          if (q.value < long_min_r) begin
            r.status = ST_INVALID;
          end else begin
            long_iv_q = q.value;
            if (!fast_q) issue_rate(1'b0, q.ota, r);
          end
        end
        OP_SET_SHORT: begin
          short_iv_q = q.value[ShortW-1:0];
          if (fast_q) issue_rate(1'b1, q.ota, r);
        end
        default: r.status = ST_UNSUP;
      endcase
    end
    r.fast_polling = fast_q;
    return r;
  endfunction

  // Script rows: plain requests, requests with a typed result, register writes
  function automatic void add_item(input logic [OpW-1:0] op, input logic addr,
                                   input logic start, input logic [QsW-1:0] v,
                                   input logic ota);
    script_row_t row;
    row.is_write = 1'b0;
    row.reg_idx  = REG_CHECKIN_INT;
    row.req      = '{op, addr, start, v, ota};
    row.typed    = 1'b0;
    row.res      = '{ST_OK, 1'b0, '0, 1'b0, 1'b0};
    script.push_back(row);
  endfunction

  function automatic void add_known(input logic [OpW-1:0] op, input logic addr,
                                    input logic start, input logic [QsW-1:0] v,
                                    input logic ota, input prc_status_e st,
                                    input logic upd, input logic [RateW-1:0] ms,
                                    input logic fast);
    add_item(op, addr, start, v, ota);
    script[script.size()-1].typed = 1'b1;
    script[script.size()-1].res   = '{st, upd, ms, 1'b0, fast};
  endfunction

  function automatic void add_write(input prc_reg_e idx, input logic [QsW-1:0] v);
    script_row_t row;
    row.is_write = 1'b1;
    row.reg_idx  = idx;
    row.req      = '{OP_TICK, 1'b0, 1'b0, v, 1'b0};
    row.typed    = 1'b0;
    row.res      = '{ST_OK, 1'b0, '0, 1'b0, 1'b0};
    script.push_back(row);
  endfunction

  function automatic poll_request_t random_request();
    poll_request_t q;
    int            pick;
    pick = $urandom_range(0, 99);
    if (pick < 35)      q.op = OP_TICK;
    else if (pick < 42) q.op = OP_START;
    else if (pick < 46) q.op = OP_STOP;
    else if (pick < 60) q.op = OP_CHECKIN_RSP;
    else if (pick < 67) q.op = OP_FAST_STOP;
    else if (pick < 75) q.op = OP_SET_LONG;
    else if (pick < 83) q.op = OP_SET_SHORT;
    else if (pick < 90) q.op = OP_RESTORE;
    else if (pick < 95) q.op = OP_OTHER;
    else q.op = OpW'($urandom_range(int'(OP_OTHER) + 1, int'(OP_LAST_CODE)));
    q.addressed  = ($urandom_range(0, 9) != 0);
    q.start_fast = ($urandom_range(0, 4) != 0);
    pick = $urandom_range(0, 19);
    if (pick < 2)      q.value = '0;
    else if (pick < 3) q.value = QS_TOP;
    else if (pick < 7) q.value = QsW'($urandom_range(0, QS_TOP));
    else               q.value = QsW'($urandom_range(0, 40));
    q.ota = ($urandom_range(0, 6) == 0);
    return q;
  endfunction

  // Write one register and mirror it in the predictor
  task automatic write_reg(input prc_reg_e idx, input logic [QsW-1:0] v);
    @(posedge clk_i);
    cfg_addr_i  <= idx;
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_CHECKIN_INT: ci_int_r     = v;
      REG_WIN_DEFAULT: win_def_r    = v[ShortW-1:0];
      REG_WIN_MAX:     win_max_r    = v[ShortW-1:0];
      REG_LONG_MIN:    long_min_r   = v;
      REG_LONG_INIT:   long_init_r  = v;
      REG_SHORT_INIT:  short_init_r = v[ShortW-1:0];
      default: ;
    endcase
  endtask

  // Hold one request until accepted, then queue its expected result
  task automatic send_request(input poll_request_t q, input logic typed,
                              input poll_result_t known);
    int           gap;
    poll_result_t predicted;
    gap = draw_gap(tx_quiet);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {{(InTdataW - QsW - 3){1'b0}}, q.ota, q.value, q.start_fast,
                      q.addressed};
    s_axis_tuser  <= q.op;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = advance_poll_state(q);
    expected_results.push_back(typed ? known : predicted);
    requests_sent++;
    if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
  endtask

  // Drop valid and wait until every expected result is back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_phase(input int ph);
    logic [QsW-1:0] v [6];
    if (ph == 0) begin
      foreach (v[i]) v[i] = '0;
    end else if (ph == 1) begin
      v[0] = QS_TOP;
      v[1] = 23'h00FFFF;
      v[2] = 23'h00FFFF;
      v[3] = QS_TOP;
      v[4] = QS_TOP;
      v[5] = 23'h00FFFF;
    end else begin
      v[0] = ($urandom_range(0, 4) == 0) ? QsW'($urandom_range(0, QS_TOP))
                                         : QsW'($urandom_range(0, 12));
      v[1] = ($urandom_range(0, 4) == 0) ? QsW'($urandom_range(0, 16'hFFFF))
                                         : QsW'($urandom_range(0, 10));
      v[2] = ($urandom_range(0, 1) == 0) ? '0 : QsW'($urandom_range(1, 20));
      v[3] = QsW'($urandom_range(0, 40));
      v[4] = QsW'($urandom_range(0, QS_TOP));
      v[5] = QsW'($urandom_range(0, 16'hFFFF));
    end
    for (int i = 0; i <= int'(REG_SHORT_INIT); i++) write_reg(prc_reg_e'(i), v[i]);
    settings_applied++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("%0t: result %0d %s expected %0d, got %0d",
                 $time, results_seen, name, want, got);
    end
  endtask

  // Compare one delivered result with the oldest expectation
  task automatic check_result(input logic [OutTdataW-1:0] d);
    poll_result_t want;
    poll_result_t got;
    got.status       = prc_status_e'(d[1:0]);
    got.rate_update  = d[2];
    got.rate_ms      = d[33:3];
    got.send_checkin = d[34];
    got.fast_polling = d[35];
    results_seen++;
    if (expected_results.size() == 0) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("%0t: result %0d expected none, got %h", $time, results_seen, d);
    end else begin
      want = expected_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("rate_update", want.rate_update, got.rate_update);
      compare_field("poll_rate_ms", want.rate_ms, got.rate_ms);
      compare_field("send_checkin", want.send_checkin, got.send_checkin);
      compare_field("fast_polling", want.fast_polling, got.fast_polling);
    end
    if (got.send_checkin === 1'b1) checkins_seen++;
    if (got.rate_update === 1'b1) rate_updates_seen++;
    if (got.status !== ST_OK) refusals_seen++;
  endtask

  // Accept results with random stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_result(m_axis_tdata);
        rx_wait = draw_gap(rx_quiet);
        if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      m_axis_tready <= (rx_wait == 0);
    end
  end

  // Abort when no handshake happens for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, stall_cycles, expected_results.size());
        $display("poll_rate_controller_unit_tb: errors");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    poll_result_t no_result;
    no_result = '{ST_OK, 1'b0, '0, 1'b0, 1'b0};

    // Reset state and refusals
    add_known(OP_RESTORE, 1'b0, 1'b0, '0, 1'b0, ST_OK, 1'b1, 31'd5000, 1'b0);
    add_known(OP_FAST_STOP, 1'b1, 1'b0, '0, 1'b0, ST_DENIED, 1'b0, '0, 1'b0);
    add_known(OP_OTHER, 1'b1, 1'b1, QS_TOP, 1'b0, ST_UNSUP, 1'b0, '0, 1'b0);
    add_known(OP_LAST_CODE, 1'b1, 1'b0, '0, 1'b1, ST_UNSUP, 1'b0, '0, 1'b0);
    add_known(OP_OTHER, 1'b0, 1'b0, '0, 1'b0, ST_OK, 1'b0, '0, 1'b0);
    add_known(OP_TICK, 1'b0, 1'b0, '0, 1'b0, ST_OK, 1'b0, '0, 1'b0);
    add_known(OP_START, 1'b1, 1'b0, '0, 1'b0, ST_OK, 1'b0, '0, 1'b0);
    add_known(OP_CHECKIN_RSP, 1'b1, 1'b1, '0, 1'b0, ST_OK, 1'b0, '0, 1'b0);
    // Long interval floor and extremes
    add_write(REG_LONG_MIN, 23'd100);
    add_known(OP_SET_LONG, 1'b1, 1'b0, 23'd99, 1'b0, ST_INVALID, 1'b0, '0, 1'b0);
    add_known(OP_SET_LONG, 1'b1, 1'b0, QS_TOP, 1'b0, ST_OK, 1'b1, 31'd1802240000, 1'b0);
    add_item(OP_SET_LONG, 1'b1, 1'b0, 23'd100, 1'b0);
    // Default window, short interval truncation, window run-out
    add_write(REG_WIN_DEFAULT, 23'd3);
    add_item(OP_CHECKIN_RSP, 1'b1, 1'b1, '0, 1'b0);
    add_item(OP_SET_SHORT, 1'b1, 1'b0, 23'h5A1234, 1'b0);
    add_item(OP_TICK, 1'b0, 1'b0, '0, 1'b0);
    add_item(OP_TICK, 1'b0, 1'b0, '0, 1'b0);
    add_item(OP_TICK, 1'b0, 1'b0, '0, 1'b0);
    // Window clamp under a busy download, restore, fast-poll stop
    add_write(REG_WIN_MAX, 23'd2);
    add_item(OP_CHECKIN_RSP, 1'b1, 1'b1, QS_TOP, 1'b1);
    add_item(OP_RESTORE, 1'b0, 1'b0, '0, 1'b0);
    add_item(OP_FAST_STOP, 1'b1, 1'b0, '0, 1'b0);
    // Window saturation, then stop
    add_write(REG_WIN_MAX, 23'd0);
    add_item(OP_CHECKIN_RSP, 1'b1, 1'b1, 23'd70000, 1'b0);
    add_item(OP_STOP, 1'b0, 1'b0, '0, 1'b0);
    // Check-in countdown, then disable it while it runs
    add_write(REG_CHECKIN_INT, 23'd2);
    add_item(OP_START, 1'b0, 1'b0, '0, 1'b0);
    add_item(OP_TICK, 1'b0, 1'b0, '0, 1'b0);
    add_item(OP_TICK, 1'b0, 1'b0, '0, 1'b0);
    add_write(REG_CHECKIN_INT, 23'd0);
    add_item(OP_TICK, 1'b0, 1'b0, '0, 1'b0);
    add_item(OP_TICK, 1'b0, 1'b0, '0, 1'b0);
    add_item(OP_START, 1'b0, 1'b0, '0, 1'b0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the script
    foreach (script[i]) begin
      if (script[i].is_write) begin
        wait_drained();
        write_reg(script[i].reg_idx, script[i].req.value);
      end else begin
        send_request(script[i].req, script[i].typed, script[i].res);
      end
    end

    // Random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      program_phase(ph);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_request(random_request(), 1'b0, no_result);
        if ($urandom_range(0, 199) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);

    $display("covered %0d requests (%0d scripted rows) under %0d random register settings",
             requests_sent, script.size(), settings_applied);
    $display("results %0d: rate updates %0d, check-ins %0d, refused commands %0d",
             results_seen, rate_updates_seen, checkins_seen, refusals_seen);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("poll_rate_controller_unit_tb: clean");
    end else begin
      $display("poll_rate_controller_unit_tb: errors");
    end
    $finish;
  end

endmodule
